// ===== rtl/i2da_pkg.sv =====
// Shared constants and elaboration helpers for the integer to decimal ASCII converter.
// Depends on nothing; every other file of the block imports it.
package i2da_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int CHAR_W = 7;
	localparam int BITS_PER_STAGE = 8;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] ASCII_NINE = 7'd57;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;

	// Number of decimal digits in the largest magnitude, 2^(bits-1).
	function automatic int dec_digits(input int bits);
		logic [64:0] p;
		int n;
		begin
			p = 65'd1 << (bits - 1);
			n = 0;
			while (p != 65'd0) begin
				p = p / 65'd10;
				n = n + 1;
			end
			return n;
		end
	endfunction

	function automatic int idx_width(input int depth);
		begin
			return (depth > 1) ? $clog2(depth) : 1;
		end
	endfunction

endpackage

// ===== rtl/i2da_if.sv =====
// Valid/ready channel interfaces of the converter: the integer item and the character item.
// Depends on i2da_pkg.
interface i2da_value_if #(
	parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface i2da_char_if;
	import i2da_pkg::*;

	logic valid;
	logic ready;
	logic [CHAR_W-1:0] character;
	logic last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

// ===== rtl/int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII text converter. Each integer item leaves as a run of
// characters, most significant first, with a leading minus for negative values and the
// last flag on the final digit. The conversion pipeline takes 1 + ceil(VALUE_BITS/8)
// register stages (five at 32 bits) and accepts a new integer every cycle unless a stall
// downstream holds it back; the serializer loads one number, emits its characters one at
// a time through the single-character output port and takes the next number only once
// it has emitted the final one. Depends on i2da_pkg, i2da_if, i2da_dabble, i2da_serializer.
module int_to_decimal_ascii #(
	parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	i2da_value_if.sink   operand,
	i2da_char_if.source  text
);
	import i2da_pkg::*;

	localparam int DIGITS = dec_digits(VALUE_BITS);
	localparam int BCD_W = 4 * DIGITS;
	localparam int NST = (VALUE_BITS + BITS_PER_STAGE - 1) / BITS_PER_STAGE;

	logic [NST:0] valid_c;
	logic [NST:0] ready_c;
	logic [NST:0] neg_c;
	logic [NST:0][VALUE_BITS-1:0] bin_c;
	logic [NST:0][BCD_W-1:0] bcd_c;

	logic valid_s1;
	logic neg_s1;
	logic [VALUE_BITS-1:0] mag_s1;

	assign operand.ready = !valid_s1 || ready_c[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (operand.ready) begin
			valid_s1 <= operand.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (operand.valid && operand.ready) begin
			neg_s1 <= operand.value[VALUE_BITS-1];
			mag_s1 <= operand.value[VALUE_BITS-1] ? (~operand.value + 1'b1) : operand.value;
		end
	end

	assign valid_c[0] = valid_s1;
	assign neg_c[0] = neg_s1;
	assign bin_c[0] = mag_s1;
	assign bcd_c[0] = '0;

	for (genvar j = 0; j < NST; j++) begin : g_stage
		localparam int REM = VALUE_BITS - j * BITS_PER_STAGE;
		localparam int STEPS = (REM > BITS_PER_STAGE) ? BITS_PER_STAGE : REM;

		i2da_dabble #(
			.VALUE_BITS (VALUE_BITS),
			.DIGITS     (DIGITS),
			.STEPS      (STEPS)
		) u_dabble (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[j]),
			.up_ready (ready_c[j]),
			.up_bin   (bin_c[j]),
			.up_bcd   (bcd_c[j]),
			.up_neg   (neg_c[j]),
			.dn_valid (valid_c[j+1]),
			.dn_ready (ready_c[j+1]),
			.dn_bin   (bin_c[j+1]),
			.dn_bcd   (bcd_c[j+1]),
			.dn_neg   (neg_c[j+1])
		);
	end

	i2da_serializer #(
		.DIGITS (DIGITS)
	) u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (valid_c[NST]),
		.up_ready (ready_c[NST]),
		.up_bcd   (bcd_c[NST]),
		.up_neg   (neg_c[NST]),
		.text     (text)
	);

endmodule

// ===== rtl/i2da_dabble.sv =====
// One register stage of the binary to BCD conversion: STEPS shift-and-add-three steps, at most BITS_PER_STAGE (8).
// Depends on i2da_pkg.
module i2da_dabble #(
	parameter int VALUE_BITS = i2da_pkg::VALUE_BITS_DEF,
	parameter int DIGITS = i2da_pkg::dec_digits(i2da_pkg::VALUE_BITS_DEF),
	parameter int STEPS = i2da_pkg::BITS_PER_STAGE
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  logic [VALUE_BITS-1:0] up_bin,
	input  logic [4*DIGITS-1:0]   up_bcd,
	input  logic                  up_neg,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output logic [VALUE_BITS-1:0] dn_bin,
	output logic [4*DIGITS-1:0]   dn_bcd,
	output logic                  dn_neg
);
	import i2da_pkg::*;

	localparam int BCD_W = 4 * DIGITS;

	logic valid_q;
	logic neg_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0] bcd_q;
	logic [VALUE_BITS-1:0] bin_n;
	logic [BCD_W-1:0] bcd_n;

	always_comb begin
		bin_n = up_bin;
		bcd_n = up_bcd;
		for (int s = 0; s < STEPS; s++) begin
			for (int k = 0; k < DIGITS; k++) begin
				if (bcd_n[4*k +: 4] >= 4'd5) begin
					bcd_n[4*k +: 4] = bcd_n[4*k +: 4] + 4'd3;
				end
			end
			bcd_n = {bcd_n[BCD_W-2:0], bin_n[VALUE_BITS-1]};
			bin_n = {bin_n[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			bin_q <= bin_n;
			bcd_q <= bcd_n;
			neg_q <= up_neg;
		end
	end

	assign dn_valid = valid_q;
	assign dn_bin = bin_q;
	assign dn_bcd = bcd_q;
	assign dn_neg = neg_q;

endmodule

// ===== rtl/i2da_serializer.sv =====
// Emits sign and significant BCD digits of a number as ASCII, one per cycle unless stalled.
// Depends on i2da_pkg and the character interface in i2da_if.
module i2da_serializer #(
	parameter int DIGITS = i2da_pkg::dec_digits(i2da_pkg::VALUE_BITS_DEF)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  logic [4*DIGITS-1:0] up_bcd,
	input  logic                up_neg,
	i2da_char_if.source         text
);
	import i2da_pkg::*;

	localparam int IDX_W = idx_width(DIGITS);

	logic busy_q;
	logic neg_q;
	logic [IDX_W-1:0] idx_q;
	logic [4*DIGITS-1:0] bcd_q;
	logic [IDX_W-1:0] top_idx;
	logic advance;

	always_comb begin
		top_idx = '0;
		for (int i = 0; i < DIGITS; i++) begin
			if (up_bcd[4*i +: 4] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	assign up_ready = !busy_q;
	assign advance = !text.valid || text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			neg_q <= 1'b0;
			text.valid <= 1'b0;
		end else begin
			if (!busy_q) begin
				if (up_valid) begin
					busy_q <= 1'b1;
					neg_q <= up_neg;
				end
			end else if (advance) begin
				if (neg_q) begin
					neg_q <= 1'b0;
				end else if (idx_q == '0) begin
					busy_q <= 1'b0;
				end
			end
			if (advance) begin
				text.valid <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && up_valid) begin
			bcd_q <= up_bcd;
			idx_q <= top_idx;
		end else if (busy_q && advance) begin
			if (neg_q) begin
				text.character <= ASCII_MINUS;
				text.last <= 1'b0;
			end else begin
				text.character <= ASCII_ZERO + {3'd0, bcd_q[4*idx_q +: 4]};
				text.last <= (idx_q == '0);
				if (idx_q != '0) begin
					idx_q <= idx_q - 1'b1;
				end
			end
		end
	end

	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid |-> (text.character == ASCII_MINUS) ||
			((text.character >= ASCII_ZERO) && (text.character <= ASCII_NINE)))
		else $error("Character outside the digit and sign set.");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(text.valid && (text.character == ASCII_MINUS)) |-> !text.last)
		else $error("Minus sign marked as the final character.");

	a_sign_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		neg_q |-> busy_q)
		else $error("Sign pending with no number in progress.");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && up_ready) |=> (busy_q && (idx_q <= IDX_W'(DIGITS - 1))))
		else $error("Accepted number did not start emission.");

endmodule

// ===== dv/int_to_decimal_ascii_test.sv =====
// Self-checking testbench for int_to_decimal_ascii: drives signed integers, predicts the
// decimal ASCII characters of each and checks every character and last flag in order.
// Depends on i2da_pkg, i2da_if and the converter RTL.
module int_to_decimal_ascii_test;
	import i2da_pkg::*;

	localparam int VALUE_BITS = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int RANDOM_PER_PHASE = 33;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic last;
	} text_char_t;

	class text_scoreboard;
		text_char_t expected_chars[$];
		int mismatches;
		int values_seen;
		int chars_seen;

		function new();
			mismatches = 0;
			values_seen = 0;
			chars_seen = 0;
		endfunction

		// The magnitude is taken as an unsigned quantity, so the most negative value converts
		// exactly.
		function void note_value(input logic signed [VALUE_BITS-1:0] v);
			logic [VALUE_BITS-1:0] raw;
			logic [VALUE_BITS-1:0] mag;
			logic negative;
			logic [3:0] digits[$];
			text_char_t c;
			raw = v;
			negative = raw[VALUE_BITS-1];
			mag = negative ? (~raw + 1'b1) : raw;
			do begin
				digits.push_front(4'(mag % 10));
				mag = mag / 10;
			end while (mag != 0);
			if (negative) begin
				c.character = ASCII_MINUS;
				c.last = 1'b0;
				expected_chars.push_back(c);
			end
			foreach (digits[i]) begin
				c.character = ASCII_ZERO + CHAR_W'(digits[i]);
				c.last = (i == digits.size() - 1);
				expected_chars.push_back(c);
			end
			values_seen++;
		endfunction

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_char(input logic [CHAR_W-1:0] ch, input logic fin);
			text_char_t want;
			chars_seen++;
			if (expected_chars.size() == 0) begin
				report($sformatf("character %0d (last %0b) with nothing expected", ch, fin));
			end else begin
				want = expected_chars.pop_front();
				if (ch !== want.character)
					report($sformatf("character %0d, expected %0d", ch, want.character));
				if (fin !== want.last)
					report($sformatf("last %0b, expected %0b", fin, want.last));
			end
		endtask

		function int pending();
			return expected_chars.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int send_idle_pct;
	int recv_idle_pct;
	int stall_cycles;
	int pow10[10];
	text_scoreboard sb;

	i2da_value_if #(.VALUE_BITS(VALUE_BITS)) value_ch();
	i2da_char_if text_ch();

	int_to_decimal_ascii #(.VALUE_BITS(VALUE_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.operand(value_ch),
		.text(text_ch)
	);

	always #5 clk = ~clk;

	task automatic send_value(input logic signed [VALUE_BITS-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			value_ch.valid <= 1'b0;
			@(posedge clk);
		end
		value_ch.valid <= 1'b1;
		value_ch.value <= v;
		@(posedge clk);
		while (!value_ch.ready)
			@(posedge clk);
		sb.note_value(v);
	endtask

	task automatic send_random_value();
		logic signed [VALUE_BITS-1:0] v;
		case ($urandom_range(3))
			0: v = $urandom;
			1: v = $urandom_range(999);
			2: v = $urandom >> $urandom_range(31);
			default: v = pow10[$urandom_range(9)] - $urandom_range(1);
		endcase
		if ($urandom_range(1))
			v = -v;
		send_value(v);
	endtask

	initial begin
		text_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (text_ch.valid && text_ch.ready)
				sb.check_char(text_ch.character, text_ch.last);
			text_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((value_ch.valid && value_ch.ready) || (text_ch.valid && text_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("no item accepted for %0d cycles", STALL_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		logic signed [VALUE_BITS-1:0] directed[$];
		sb = new();
		arst_n = 1'b0;
		send_idle_pct = 15;
		recv_idle_pct = 85;
		value_ch.valid = 1'b0;
		value_ch.value = '0;
		pow10[0] = 1;
		for (int i = 1; i < 10; i++)
			pow10[i] = pow10[i-1] * 10;
		directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647, 32'sh80000000,
			-2147483647, 999999999, 1000000000, -1000000000, 32'h55555555, 32'hAAAAAAAA,
			1234567890, -123456789};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 15;
					recv_idle_pct = 85;
				end
				1: begin
					send_idle_pct = 85;
					recv_idle_pct = 15;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			if (phase == 0)
				foreach (directed[i])
					send_value(directed[i]);
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				send_random_value();
		end
		value_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("%0d integers converted to %0d characters under three idling patterns,",
			sb.values_seen, sb.chars_seen);
		$display("including zero, single digits, powers of ten and both 32-bit extremes.");
		if (sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
